FILE: rtl/iwdq_pkg.sv
// Package for the integer weight dequantizer.
// Holds payload structs, register indexes and the half-to-single scale helpers.
package iwdq_pkg;

    typedef struct packed {
        logic [7:0] weight_byte;
        logic       high_nibble_used;
        logic       last_byte;
    } in_beat_t;

    typedef struct packed {
        logic [31:0] value_bits;
        logic        last_value;
        logic        scale_error;
    } out_beat_t;

    typedef enum logic [0:0] {
        REG_ELEMENT_WIDTH_MODE = 1'b0,
        REG_SCALE_HALF         = 1'b1
    } reg_index_t;

    localparam logic        MODE_RESET  = 1'b1;
    localparam logic [15:0] SCALE_RESET = 16'h3C00;

    // Widen a half to single, normalizing subnormals.
    function automatic logic [31:0] half_to_single(input logic [15:0] h);
        logic [4:0] ex;
        logic [9:0] man;
        logic [7:0] fex;
        logic [9:0] fman;
        logic [3:0] lz;
        ex   = h[14:10];
        man  = h[9:0];
        fex  = 8'd0;
        fman = 10'd0;
        lz   = 4'd0;
        if (ex == 5'd0) begin
            if (man != 10'd0) begin
                for (int i = 0; i < 10; i++) begin
                    if (man[i]) begin
                        lz = 4'(9 - i);
                    end
                end
                fex  = 8'd113 - 8'(lz) - 8'd1;
                fman = 10'(man << (lz + 4'd1));
            end
        end else if (ex == 5'd31) begin
            fex  = 8'd255;
            fman = man;
        end else begin
            fex  = 8'(ex) + 8'd112;
            fman = man;
        end
        return {h[15], fex, fman, 13'd0};
    endfunction

    function automatic logic scale_bad(input logic [31:0] f);
        return (f[30:23] == 8'hFF) || f[31] || (f[30:0] == 31'd0);
    endfunction

endpackage

FILE: rtl/int_weight_dequantizer_core.sv
// Top level of the integer weight dequantizer.
// Depends on iwdq_pkg and iwdq_mul.
//
// Usage: bytes enter on in_valid/in_stall/in_data; results leave on
// out_valid/out_stall/out_data, one beat per cycle unless stalled. Registers
// are written on cfg_valid/cfg_ready with cfg_index and cfg_data, only while
// idle: the user must ensure this, as the block does not enforce it.
// In 8-bit mode each byte gives one result; in 4-bit mode low nibble then
// high nibble (the high one dropped when high_nibble_used is 0). A bad scale
// gives one error beat per byte. A byte's first result shows in the cycle
// after it is accepted. Throughput is one result per cycle unless stalled,
// set by the single output register: one byte per cycle in 8-bit mode.
// Reset empties the output stage and loads mode 8-bit and scale 1.0.
// When the receiver stalls, the output beat holds and the input stalls in
// the same cycle; the input also stalls while a high nibble is pending.
module int_weight_dequantizer_core
    import iwdq_pkg::*;
(
    input  logic        clk,
    input  logic        rst_n,
    input  logic        in_valid,
    output logic        in_stall,
    input  in_beat_t    in_data,
    output logic        out_valid,
    input  logic        out_stall,
    output out_beat_t   out_data,
    input  logic        cfg_valid,
    output logic        cfg_ready,
    input  logic        cfg_index,
    input  logic [15:0] cfg_data
);
    logic        mode_reg;
    logic [15:0] scale_reg;
    logic        out_valid_reg;
    out_beat_t   out_reg;
    logic        hi_pend_reg;
    logic [3:0]  hi_nib_reg;
    logic        hi_last_reg;
    logic [31:0] scale_f;
    logic        bad;
    logic        take;
    logic        adv;
    logic signed [7:0] v_sel;
    logic [31:0] prod;
    out_beat_t   out_next;
    logic        hi_pend_next;

    assign scale_f   = half_to_single(scale_reg);
    assign bad       = scale_bad(scale_f);
    assign cfg_ready = 1'b1;
    assign adv       = !out_valid_reg || !out_stall;
    assign in_stall  = !adv || hi_pend_reg;
    assign take      = in_valid && !in_stall;
    assign out_valid = out_valid_reg;
    assign out_data  = out_reg;

    iwdq_mul u_mul (.v(v_sel), .scale(scale_f), .result(prod));

    always_comb
    begin
        hi_pend_next = hi_pend_reg;
        out_next     = out_reg;
        v_sel        = 8'sd0;
        if (hi_pend_reg) begin
            v_sel        = 8'(signed'(hi_nib_reg));
            out_next     = '{value_bits: prod, last_value: hi_last_reg, scale_error: 1'b0};
            hi_pend_next = 1'b0;
        end else if (mode_reg) begin
            v_sel    = signed'(in_data.weight_byte);
            out_next = '{value_bits: prod, last_value: in_data.last_byte, scale_error: 1'b0};
        end else begin
            v_sel        = 8'(signed'(in_data.weight_byte[3:0]));
            hi_pend_next = in_data.high_nibble_used && !bad;
            out_next     = '{value_bits: prod,
                             last_value: in_data.last_byte && !hi_pend_next,
                             scale_error: 1'b0};
        end
        if (!hi_pend_reg && bad) begin
            out_next = '{value_bits: 32'd0, last_value: in_data.last_byte, scale_error: 1'b1};
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n) begin
            mode_reg      <= MODE_RESET;
            scale_reg     <= SCALE_RESET;
            out_valid_reg <= 1'b0;
            hi_pend_reg   <= 1'b0;
        end else begin
            if (cfg_valid) begin
                unique case (reg_index_t'(cfg_index))
                    REG_ELEMENT_WIDTH_MODE: mode_reg  <= cfg_data[0];
                    REG_SCALE_HALF:         scale_reg <= cfg_data;
                    default:                mode_reg  <= mode_reg;
                endcase
            end
            if (adv) begin
                out_valid_reg <= hi_pend_reg || take;
                if (hi_pend_reg || take) begin
                    hi_pend_reg <= hi_pend_next;
                end
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (adv && (hi_pend_reg || take)) begin
            out_reg <= out_next;
        end
        if (take) begin
            hi_nib_reg  <= in_data.weight_byte[7:4];
            hi_last_reg <= in_data.last_byte;
        end
    end
endmodule

FILE: rtl/iwdq_mul.sv
// Multiply of a small signed integer by a positive finite single, truncating the product.
// Depends on iwdq_pkg only for style consistency of the import.
module iwdq_mul
    import iwdq_pkg::*;
(
    input  logic signed [7:0] v,
    input  logic [31:0]       scale,
    output logic [31:0]       result
);
    logic [7:0]  mag;
    logic [23:0] sig;
    logic [31:0] prod;
    logic [4:0]  msb;
    logic [8:0]  ex;
    logic [22:0] frac;
    logic [31:0] sh;
    logic [8:0]  lsh;

    always_comb
    begin
        mag  = v[7] ? 8'(-v) : 8'(v);
        sig  = (scale[30:23] == 8'd0) ? {1'b0, scale[22:0]} : {1'b1, scale[22:0]};
        prod = 32'(mag) * 32'(sig);
        msb  = 5'd0;
        for (int i = 0; i < 32; i++) begin
            if (prod[i]) begin
                msb = 5'(i);
            end
        end
        ex   = 9'(scale[30:23]) + 9'(msb) - 9'd23
             + ((scale[30:23] == 8'd0) ? 9'd1 : 9'd0);
        sh   = 32'd0;
        lsh  = 9'd0;
        frac = 23'd0;
        if (msb >= 5'd23) begin
            sh = prod >> (msb - 5'd23);
        end else begin
            sh = prod << (5'd23 - msb);
        end
        if (ex[8] || ex == 9'd0) begin
            // subnormal result: shift so exponent field becomes zero
            lsh  = 9'd1 - ex;
            sh   = sh >> lsh;
            frac = sh[22:0];
            result = {v[7], 8'd0, frac};
        end else begin
            frac   = sh[22:0];
            result = {v[7], ex[7:0], frac};
        end
        if (mag == 8'd0) begin
            result = 32'd0;
        end
    end
endmodule

FILE: rtl/iwdq_checker.sv
// Port-level checks for the integer weight dequantizer.
// Depends on iwdq_pkg; bound to int_weight_dequantizer_core.
module iwdq_checker
    import iwdq_pkg::*;
(
    input logic      clk,
    input logic      rst_n,
    input logic      in_valid,
    input logic      in_stall,
    input logic      out_valid,
    input logic      out_stall,
    input out_beat_t out_data
);
    a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && out_stall |=> out_valid && $stable(out_data))
        else $error("output beat dropped under stall");
    a_err_zero: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && out_data.scale_error |-> out_data.value_bits == 32'd0)
        else $error("error beat with nonzero value");
    a_stall_back: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && out_stall |-> in_stall)
        else $error("input taken while output blocked");
    a_no_src: assert property (@(posedge clk) disable iff (!rst_n)
        !out_valid && !$past(in_valid) |-> !in_stall)
        else $error("stall with nothing pending");
endmodule

bind int_weight_dequantizer_core iwdq_checker u_iwdq_checker (
    .clk(clk), .rst_n(rst_n), .in_valid(in_valid), .in_stall(in_stall),
    .out_valid(out_valid), .out_stall(out_stall), .out_data(out_data)
);
